/* design/latent_distance_or_dot_effect_unit_macros.svh */
// Assertion macros for the latent distance / dot effect unit.
// Included by the top level; depends on nothing else.
`ifndef LATENT_DISTANCE_OR_DOT_EFFECT_UNIT_MACROS_SVH
`define LATENT_DISTANCE_OR_DOT_EFFECT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lde same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lde next-cycle check failed");

`endif

/* design/lde_pkg.sv */
// Shared types, widths, mode codes and saturation helpers of the effect unit.
// No dependencies; the macros header apart, every other file uses it.
`timescale 1ns / 1ps

package lde_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ACC_W   = 38;
    localparam int OUT_W   = 37;
    localparam int MODE_W  = 2;
    localparam int FRAC_W  = 16;
    localparam int ROOT_W  = 27;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int STEP_W  = $clog2(ROOT_W + 1);

    localparam logic [MODE_W-1:0] MODE_DIST   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DOT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQDIST = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [ACC_W:0]     t_acc_wide;
    typedef logic signed [OUT_W-1:0]   t_effect;
    typedef logic [MODE_W-1:0]         t_mode;

    localparam t_acc_wide ACC_MAX_W = t_acc_wide'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam t_acc_wide ACC_MIN_W = t_acc_wide'(-(64'sd1 <<< (ACC_W - 1)));
    localparam t_acc_wide OUT_MAX_W = t_acc_wide'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam t_acc_wide OUT_MIN_W = t_acc_wide'(-(64'sd1 <<< (OUT_W - 1)));

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic root_start;
        logic emit;
    } t_ctrl_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_last;
        logic mode_dist;
        logic root_done;
    } t_dp_status;

    function automatic t_acc clamp_acc(input t_acc_wide x);
        t_acc r;
        if (x > ACC_MAX_W) begin
            r = ACC_MAX_W[ACC_W-1:0];
        end else if (x < ACC_MIN_W) begin
            r = ACC_MIN_W[ACC_W-1:0];
        end else begin
            r = x[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic t_effect clamp_out(input t_acc_wide x);
        t_effect r;
        if (x > OUT_MAX_W) begin
            r = OUT_MAX_W[OUT_W-1:0];
        end else if (x < OUT_MIN_W) begin
            r = OUT_MIN_W[OUT_W-1:0];
        end else begin
            r = x[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/lde_if.sv */
// Channel interfaces: coordinate pair words in, effect words out.
// Depends on lde_pkg.
`timescale 1ns / 1ps

interface lde_in_if;
    logic            valid;
    logic            ready;
    lde_pkg::t_coord u_coord;
    lde_pkg::t_coord v_coord;
    logic            is_last;

    modport source (output valid, output u_coord, output v_coord, output is_last,
                    input ready);
    modport sink   (input valid, input u_coord, input v_coord, input is_last,
                    output ready);
endinterface

interface lde_out_if;
    logic             valid;
    logic             ready;
    lde_pkg::t_effect effect_value;
    logic             overflow;

    modport source (output valid, output effect_value, output overflow, input ready);
    modport sink   (input valid, input effect_value, input overflow, output ready);
endinterface

/* design/lde_sqrt.sv */
// Bit-serial floor square root, one root bit per cycle.
// Depends on lde_pkg.
`timescale 1ns / 1ps

module lde_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lde_pkg::RAD_W-1:0]  i_radicand,
    output logic                       o_done,
    output logic [lde_pkg::ROOT_W-1:0] o_root
);
    import lde_pkg::*;

    localparam logic [STEP_W-1:0] ROOT_STEPS = STEP_W'(ROOT_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [ROOT_W:0]   r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;

    logic [ROOT_W+2:0] w_rem_sh;
    logic [ROOT_W+2:0] w_trial;
    logic [ROOT_W+2:0] w_diff;
    logic              w_ge;

    // Bring down two radicand bits and try root*4+1.
    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_diff   = w_rem_sh - w_trial;
    assign w_ge     = (w_rem_sh >= w_trial);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = ROOT_STEPS;
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad  = {r_rad[RAD_W-3:0], 2'b00};
            n_rem  = w_ge ? w_diff[ROOT_W:0] : w_rem_sh[ROOT_W:0];
            n_root = {r_root[ROOT_W-2:0], w_ge};
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* design/lde_datapath.sv */
// Datapath: mode register, multiplier, saturating accumulator, root unit, result register.
// Depends on lde_pkg and lde_sqrt.
`timescale 1ns / 1ps

module lde_datapath #(
    parameter int MAX_DIM = 16,
    parameter int CNT_W   = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  lde_pkg::t_mode      i_cfg_data,
    input  lde_pkg::t_coord     i_u_coord,
    input  lde_pkg::t_coord     i_v_coord,
    input  logic                i_is_last,
    input  lde_pkg::t_ctrl_cmd  i_cmd,
    output lde_pkg::t_dp_status o_status,
    output lde_pkg::t_effect    o_effect_value,
    output logic                o_overflow
);
    import lde_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DIM);

    t_mode                      r_mode;
    t_coord                     r_u, r_v;
    logic                       r_last;
    logic signed [PROD_W-1:0]   r_prod;
    t_acc                       r_acc;
    logic [CNT_W-1:0]           r_count;
    logic                       r_ovf_seen;
    t_effect                    r_effect;
    logic                       r_overflow;

    logic signed [DIFF_W-1:0]   w_diff, w_opa, w_opb;
    logic signed [PROD_W-1:0]   w_prod;
    t_acc_wide                  w_sum, w_neg;
    logic [RAD_W-1:0]           w_radicand;
    logic                       w_root_done;
    logic [ROOT_W-1:0]          w_root;
    t_effect                    w_result;

    assign w_diff = DIFF_W'(r_u) - DIFF_W'(r_v);
    assign w_opa  = (r_mode == MODE_DOT) ? DIFF_W'(r_u) : w_diff;
    assign w_opb  = (r_mode == MODE_DOT) ? DIFF_W'(r_v) : w_diff;
    assign w_prod = w_opa * w_opb;

    assign w_sum = t_acc_wide'(r_acc) + t_acc_wide'(r_prod);
    assign w_neg = t_acc_wide'(0) - t_acc_wide'(r_acc);

    // Negative sums read as zero under the root.
    assign w_radicand = r_acc[ACC_W-1] ? '0 : RAD_W'({r_acc[ACC_W-2:0], FRAC_W'(0)});

    lde_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_start),
        .i_radicand (w_radicand),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    always_comb begin
        unique case (r_mode)
            MODE_DIST: w_result = t_effect'(0) - OUT_W'(w_root);
            MODE_DOT:  w_result = clamp_out(t_acc_wide'(r_acc));
            default:   w_result = clamp_out(w_neg);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_DIST;
            r_acc      <= '0;
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.acc) begin
                if (r_count < CNT_LIMIT) begin
                    r_acc   <= clamp_acc(w_sum);
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf_seen <= 1'b1;
                end
            end else if (i_cmd.emit) begin
                r_acc      <= '0;
                r_count    <= '0;
                r_ovf_seen <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_u    <= i_u_coord;
            r_v    <= i_v_coord;
            r_last <= i_is_last;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.emit) begin
            r_effect   <= w_result;
            r_overflow <= r_ovf_seen;
        end
    end

    assign o_status.is_last   = r_last;
    assign o_status.mode_dist = (r_mode == MODE_DIST);
    assign o_status.root_done = w_root_done;
    assign o_effect_value     = r_effect;
    assign o_overflow         = r_overflow;

endmodule

/* design/lde_ctrl.sv */
// Controller: sequences capture, multiply, accumulate, root and result load.
// Depends on lde_pkg.
`timescale 1ns / 1ps

module lde_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lde_pkg::t_ctrl_cmd  o_cmd,
    input  lde_pkg::t_dp_status i_status
);
    import lde_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL     = 3'd1;
    localparam logic [2:0] S_ACC     = 3'd2;
    localparam logic [2:0] S_ROOT_LD = 3'd3;
    localparam logic [2:0] S_ROOT    = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (!i_status.is_last) begin
                    n_state = S_IDLE;
                end else if (i_status.mode_dist) begin
                    n_state = S_ROOT_LD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_ROOT_LD: begin
                o_cmd.root_start = 1'b1;
                n_state          = S_ROOT;
            end
            S_ROOT: begin
                if (i_status.root_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result word until taken; a new load may replace it in the same cycle.
    assign n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/latent_distance_or_dot_effect_unit.sv */
// Top level of the latent distance / dot effect unit.
// Depends on lde_pkg, lde_if, lde_ctrl, lde_datapath, lde_sqrt and the macros header.
//
//   channel  dir  handshake          payload
//   i_in     in   valid / ready      u_coord[15:0] s, v_coord[15:0] s, is_last
//   o_out    out  valid / ready      effect_value[36:0] s, overflow
//   cfg      in   i_cfg_we           i_cfg_data[1:0] = effect_mode
//
// A coordinate pair word passes capture, multiply and accumulate. The word
// marked last then loads the result register in dot and squared distance
// modes; in distance mode it first runs root load, the root iterations of the
// bit-serial square root unit and its registered done flag, then the result
// load.
// Reset (i_rst_n low at a clock edge) clears mode, accumulator, count and flags.
// The result register holds a finished word while the next pairs are taken;
// only a second result waits for it to drain.
`timescale 1ns / 1ps
`include "latent_distance_or_dot_effect_unit_macros.svh"

module latent_distance_or_dot_effect_unit #(
    parameter int MAX_DIM = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  lde_pkg::t_mode        i_cfg_data,
    lde_in_if.sink                i_in,
    lde_out_if.source             o_out
);
    import lde_pkg::*;

    // Pair counter saturates at MAX_DIM, so it must hold that value itself.
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    lde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    lde_datapath #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_u_coord      (i_in.u_coord),
        .i_v_coord      (i_in.v_coord),
        .i_is_last      (i_in.is_last),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_effect_value (o_out.effect_value),
        .o_overflow     (o_out.overflow)
    );

    // An accepted word keeps the unit busy for the next cycle.
    `LDE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // A result is loaded only into a free or draining output register.
    `LDE_ASSERT_NOW(a_load_into_free_slot, i_clk, i_rst_n, w_cmd.emit, !o_out.valid || o_out.ready)
    // A loaded result is shown on the next cycle.
    `LDE_ASSERT_NEXT(a_load_shows_word, i_clk, i_rst_n, w_cmd.emit, o_out.valid)
    // The root unit never starts while a word is being taken in.
    `LDE_ASSERT_NOW(a_root_not_on_accept, i_clk, i_rst_n, w_cmd.root_start, !w_cmd.capture)

endmodule

/* tb/tb_latent_distance_or_dot_effect_unit.sv */
// Self-checking bench for the latent distance / dot effect unit: a directed table
// followed by random vector phases, with results checked against a built-in predictor.
// Depends on lde_pkg, lde_if and the latent_distance_or_dot_effect_unit RTL.
`timescale 1ns / 1ps

module tb_latent_distance_or_dot_effect_unit;
    import lde_pkg::*;

    localparam int MAX_PAIRS    = 16;
    localparam int RANDOM_ITEMS = 1925;
    // Worst word in the pipe: capture, multiply and accumulate per pair, plus root load,
    // root steps and result load on the last pair in distance mode. Round up generously.
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PRINT_CAP    = 100;

    // The fourth selector code has no name in the package; it folds into squared distance.
    localparam t_mode MODE_SPARE = 2'd3;

    localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam longint ACC_LO = -(64'sd1 <<< (ACC_W - 1));
    localparam longint EFF_HI = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam longint EFF_LO = -(64'sd1 <<< (OUT_W - 1));

    typedef struct packed {
        t_coord u;
        t_coord v;
        logic   last;
    } t_pair_word;

    typedef struct packed {
        t_effect value;
        logic    ovf;
    } t_effect_word;

    typedef enum logic {ROW_WORD, ROW_MODE} t_row_kind;

    // One row of the directed table: either a mode write or a pair word, with an
    // optional hand-computed result that replaces the predicted one.
    typedef struct packed {
        t_row_kind    kind;
        t_mode        mode;
        t_pair_word   word;
        logic         typed;
        t_effect_word want;
    } t_dir_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_mode i_cfg_data;

    lde_in_if  pair_if ();
    lde_out_if effect_if ();

    latent_distance_or_dot_effect_unit #(
        .MAX_DIM (MAX_PAIRS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (pair_if),
        .o_out      (effect_if)
    );

    // Predictor state: mirrors what the unit holds between pairs.
    t_mode                  mode_now;
    logic signed [ACC_W-1:0] sum_acc;
    int unsigned            pairs_taken;
    bit                     too_many;

    t_effect_word effect_q[$];
    int           mismatches;
    int           quiet;
    int           burst_left;
    int           holds_asked;
    int           holds_served;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    // Floor square root: settle one root bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Fold one pair into the running sum, or mark overflow once MAX_PAIRS are taken; on the
    // last pair build the effect word for the current mode and clear for the next vector pair.
    function automatic bit fold_pair(input t_pair_word w, output t_effect_word eff);
        longint          diff;
        longint          term;
        longint          wide;
        longint          res;
        longint unsigned radicand;
        eff = '0;
        if (pairs_taken < MAX_PAIRS) begin
            if (mode_now == MODE_DOT) begin
                term = longint'(w.u) * longint'(w.v);
            end else begin
                diff = longint'(w.u) - longint'(w.v);
                term = diff * diff;
            end
            wide = longint'(sum_acc) + term;
            if (wide > ACC_HI) begin
                wide = ACC_HI;
            end else if (wide < ACC_LO) begin
                wide = ACC_LO;
            end
            sum_acc = wide[ACC_W-1:0];
            pairs_taken++;
        end else begin
            too_many = 1'b1;
        end
        if (!w.last) begin
            return 1'b0;
        end
        case (mode_now)
            MODE_DIST: begin
                // A sum driven negative by earlier dot-mode pairs counts as zero.
                radicand = (sum_acc < 0) ? 64'd0 : (longint'(sum_acc) <<< FRAC_W);
                res = -longint'(floor_root(radicand));
            end
            MODE_DOT: begin
                res = longint'(sum_acc);
            end
            default: begin
                res = -longint'(sum_acc);
            end
        endcase
        if (res > EFF_HI) begin
            res = EFF_HI;
        end else if (res < EFF_LO) begin
            res = EFF_LO;
        end
        eff.value = res[OUT_W-1:0];
        eff.ovf   = too_many;
        sum_acc     = '0;
        pairs_taken = 0;
        too_many    = 1'b0;
        return 1'b1;
    endfunction

    // Offer one pair word. Called at a falling edge; returns at a falling edge.
    // The sender runs in bursts: at the end of a burst, it may drop valid for a random gap.
    task automatic offer_pair(input t_pair_word w, input logic typed, input t_effect_word want);
        int           gap;
        t_effect_word eff;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                pair_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        pair_if.valid   = 1'b1;
        pair_if.u_coord = w.u;
        pair_if.v_coord = w.v;
        pair_if.is_last = w.last;
        do @(posedge i_clk); while (!pair_if.ready);
        if (fold_pair(w, eff)) begin
            effect_q.push_back(typed ? want : eff);
        end
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected effect word has come back.
    task automatic wait_drained();
        pair_if.valid = 1'b0;
        burst_left    = 0;
        while (effect_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the mode register once the unit is idle. Pairs without a result may
    // still be in the pipe, so let the full latency pass before the write.
    task automatic write_mode(input t_mode m);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = m;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        mode_now = m;
    endtask

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return t_coord'(int'($urandom_range(0, 511)) - 256);
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(MAX_PAIRS + 1, MAX_PAIRS + 6);
            1:       return MAX_PAIRS;
            2, 3:    return 1;
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    // Compare every accepted effect word with the oldest expectation.
    always @(posedge i_clk) begin : effect_check
        t_effect_word want;
        if (i_rst_n && effect_if.valid && effect_if.ready) begin
            if (effect_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected effect word %0d",
                                        $signed(effect_if.effect_value)));
            end else begin
                want = effect_q.pop_front();
                if (effect_if.effect_value !== want.value) begin
                    flag_mismatch($sformatf("effect_value got %0d want %0d",
                                            $signed(effect_if.effect_value),
                                            $signed(want.value)));
                end
                if (effect_if.overflow !== want.ovf) begin
                    flag_mismatch($sformatf("overflow got %b want %b",
                                            effect_if.overflow, want.ovf));
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pair_if.valid && pair_if.ready) ||
            (effect_if.valid && effect_if.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: stall on a changing pattern; serve each long hold-off request by
    // keeping ready low for HOLD_CYCLES, counted here.
    initial begin : effect_sink
        int style;
        int span;
        int tick;
        effect_if.ready = 1'b0;
        tick            = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 160);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                if (holds_served != holds_asked) begin
                    holds_served++;
                    effect_if.ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (style)
                    0:       effect_if.ready = 1'b1;
                    1:       effect_if.ready = ($urandom_range(0, 3) != 0);
                    2:       effect_if.ready = ((tick % 3) != 0);
                    default: effect_if.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        t_dir_row     directed[$];
        t_pair_word   w;
        int           words_sent;
        int           phase;
        int           vec_total;
        int           len;
        bit           hold_phase;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = MODE_DIST;
        pair_if.valid   = 1'b0;
        pair_if.u_coord = '0;
        pair_if.v_coord = '0;
        pair_if.is_last = 1'b0;
        mode_now        = MODE_DIST;
        sum_acc         = '0;
        pairs_taken     = 0;
        too_many        = 1'b0;
        burst_left      = 0;
        holds_asked     = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table. Mode after reset is distance, so the first rows check
        // the reset value of the register without writing it.
        directed.push_back('{ROW_WORD, MODE_DIST, '{16'sh0000, 16'sh0000, 1'b1},
                            1'b1, '{37'sd0, 1'b0}});
        // Distance 1.0 comes out as -1.0 in Q.16.
        directed.push_back('{ROW_WORD, MODE_DIST, '{16'sh0100, 16'sh0000, 1'b1},
                            1'b1, '{-37'sd65536, 1'b0}});
        // Widest difference: sqrt(65535^2 * 2^16) = 65535 * 256.
        directed.push_back('{ROW_WORD, MODE_DIST, '{16'sh7FFF, 16'sh8000, 1'b1},
                            1'b1, '{-37'sd16776960, 1'b0}});
        directed.push_back('{ROW_MODE, MODE_DOT, '{16'sh0, 16'sh0, 1'b0}, 1'b0, '0});
        directed.push_back('{ROW_WORD, MODE_DOT, '{16'sh7FFF, 16'sh7FFF, 1'b1},
                            1'b1, '{37'sd1073676289, 1'b0}});
        directed.push_back('{ROW_WORD, MODE_DOT, '{16'sh8000, 16'sh8000, 1'b1},
                            1'b1, '{37'sd1073741824, 1'b0}});
        directed.push_back('{ROW_WORD, MODE_DOT, '{16'sh8000, 16'sh7FFF, 1'b1},
                            1'b1, '{-37'sd1073709056, 1'b0}});
        directed.push_back('{ROW_MODE, MODE_SQDIST, '{16'sh0, 16'sh0, 1'b0}, 1'b0, '0});
        directed.push_back('{ROW_WORD, MODE_SQDIST, '{16'sh7FFF, 16'sh8000, 1'b1},
                            1'b1, '{-37'sd4294836225, 1'b0}});
        // Spare selector behaves as negative squared distance.
        directed.push_back('{ROW_MODE, MODE_SPARE, '{16'sh0, 16'sh0, 1'b0}, 1'b0, '0});
        directed.push_back('{ROW_WORD, MODE_SPARE, '{16'sh0100, 16'sh0000, 1'b1},
                            1'b1, '{-37'sd65536, 1'b0}});
        // Too many pairs: fill all slots with the widest difference, then one more
        // pair that must be dropped and must raise overflow.
        for (int k = 0; k < MAX_PAIRS; k++) begin
            directed.push_back('{ROW_WORD, MODE_SPARE, '{16'sh7FFF, 16'sh8000, 1'b0},
                                1'b0, '0});
        end
        directed.push_back('{ROW_WORD, MODE_SPARE, '{16'sh7FFF, 16'sh8000, 1'b1},
                            1'b1, '{-37'sd68717379600, 1'b1}});

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_MODE) begin
                write_mode(directed[i].mode);
            end else begin
                offer_pair(directed[i].word, directed[i].typed, directed[i].want);
            end
        end

        // Random phases: each picks a mode, sends a run of vectors, and sometimes
        // leaves a vector unfinished so that the next mode write lands mid-vector.
        words_sent = 0;
        phase      = 0;
        while (words_sent < RANDOM_ITEMS) begin
            write_mode((phase < 4) ? t_mode'(phase) : t_mode'($urandom_range(0, 3)));
            // Phase 2: stall the receiver for a long stretch while short vectors keep
            // coming, so the result register fills and the input backs up.
            hold_phase = (phase == 2);
            if (hold_phase) begin
                holds_asked++;
            end
            vec_total = hold_phase ? 30 : $urandom_range(4, 16);
            for (int n = 0; n < vec_total && words_sent < RANDOM_ITEMS; n++) begin
                if ((phase == 5 && n == 2) || $urandom_range(0, 15) == 0) begin
                    wait_drained();
                end
                len = hold_phase ? $urandom_range(1, 2) : pick_len();
                for (int k = 0; k < len; k++) begin
                    w.u    = pick_coord();
                    w.v    = ($urandom_range(0, 7) == 0) ? w.u : pick_coord();
                    w.last = (k == len - 1);
                    offer_pair(w, 1'b0, '0);
                    words_sent++;
                end
            end
            if ($urandom_range(0, 2) == 0 && words_sent + 40 < RANDOM_ITEMS) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    w.u    = pick_coord();
                    w.v    = pick_coord();
                    w.last = 1'b0;
                    offer_pair(w, 1'b0, '0);
                    words_sent++;
                end
            end
            phase++;
        end

        // Drain: wait for every expected word, then the full latency to catch strays.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
